FILE: design/tsq_pkg.sv
`timescale 1ns / 1ps

package tsq_pkg;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_STUCK   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_EMA_ALPHA   = 2'd0,
        CFG_JUMP_LIMIT  = 2'd1,
        CFG_STUCK_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [13:0] raw_temp;
        logic               read_fault;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic signed [11:0] filtered_temp;
        logic signed [19:0] smoothed_temp;
    } out_word_t;

    localparam logic signed [13:0] TEMP_MIN = -14'sd80;
    localparam logic signed [13:0] TEMP_MAX = 14'sd1600;

    localparam logic [16:0] ALPHA_ONE         = 17'd65536;
    localparam logic [16:0] EMA_ALPHA_RESET   = 17'd16384;
    localparam logic [10:0] JUMP_LIMIT_RESET  = 11'd400;
    localparam logic [15:0] STUCK_LIMIT_RESET = 16'd30;

endpackage

FILE: design/temperature_sample_qualifier_core.sv
`timescale 1ns / 1ps

// temperature sample qualifier
// in channel: one word per sensor sample (raw_temp in quarter degrees, read_fault),
// taken at a clock edge with in_valid high and in_stall low
// out channel: one word per sample (status, filtered_temp, smoothed_temp),
// taken at a clock edge with out_valid high and out_stall low
// cfg channel: cfg_ready is always high; cfg_index selects ema_alpha, jump_limit
// or stuck_limit, cfg_data carries the value; index 3 is ignored
// an accepted input word passes the input register and then the output register
// throughput: one word per cycle while out_stall is low; the input register, one pass of compare,
// glitch select, subtract and a 29x18 multiply-add, and the output register
// set that figure, since the filter state updates in the same pass
// stall: while out_stall holds a finished word, the next word still enters the
// input register; in_stall rises only when both registers are full
// reset: all filter state and both word registers clear, the config registers
// return to alpha 16384, jump limit 400, stuck limit 30

module temperature_sample_qualifier_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tsq_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output tsq_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);
    import tsq_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    in_word_t           in_word_reg;
    in_word_t           in_word_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_word_t          out_word_reg;
    out_word_t          out_word_next;

    logic [16:0]        ema_alpha_reg;
    logic [16:0]        ema_alpha_next;
    logic [10:0]        jump_limit_reg;
    logic [10:0]        jump_limit_next;
    logic [15:0]        stuck_limit_reg;
    logic [15:0]        stuck_limit_next;

    logic signed [11:0] last_good_reg;
    logic signed [11:0] last_good_next;
    logic               last_good_valid_reg;
    logic               last_good_valid_next;
    logic signed [11:0] stuck_ref_reg;
    logic signed [11:0] stuck_ref_next;
    logic               stuck_ref_valid_reg;
    logic               stuck_ref_valid_next;
    logic [15:0]        same_count_reg;
    logic [15:0]        same_count_next;
    logic signed [27:0] average_reg;
    logic signed [27:0] average_next;
    logic               average_valid_reg;
    logic               average_valid_next;

    logic               advance;
    logic signed [13:0] t;
    logic               sample_bad;
    logic signed [11:0] t_short;
    logic signed [12:0] diff;
    logic        [12:0] diff_abs;
    logic               glitch;
    logic signed [11:0] f;
    logic        [15:0] count_inc;
    logic        [15:0] count_cmp;
    logic               stuck;
    logic signed [27:0] sample_q;
    logic signed [27:0] avg_base;
    logic signed [28:0] avg_diff;
    logic signed [17:0] alpha_eff;
    logic signed [46:0] product;
    logic signed [46:0] product_rnd;
    logic signed [27:0] avg_new;
    logic signed [27:0] smooth_sum;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

    // qualify and glitch reject
    assign t          = in_word_reg.raw_temp;
    assign sample_bad = in_word_reg.read_fault || (t < TEMP_MIN) || (t > TEMP_MAX);
    assign t_short    = t[11:0];
    assign diff       = {t_short[11], t_short} - {last_good_reg[11], last_good_reg};
    assign diff_abs   = diff[12] ? 13'(-diff) : 13'(diff);
    assign glitch     = last_good_valid_reg && (diff_abs > {2'b00, jump_limit_reg});
    assign f          = glitch ? last_good_reg : t_short;

    // stuck watchdog
    assign count_inc = (same_count_reg == 16'hFFFF) ? same_count_reg : same_count_reg + 16'd1;
    assign count_cmp = (f == stuck_ref_reg) ? count_inc : 16'd0;
    assign stuck     = stuck_ref_valid_reg && (count_cmp >= stuck_limit_reg);

    // moving average
    assign sample_q    = {f, 16'd0};
    assign avg_base    = average_valid_reg ? average_reg : sample_q;
    assign avg_diff    = {sample_q[27], sample_q} - {avg_base[27], avg_base};
    assign alpha_eff   = (ema_alpha_reg > ALPHA_ONE) ? 18'sd65536
                                                     : $signed({1'b0, ema_alpha_reg});
    assign product     = 47'(avg_diff) * 47'(alpha_eff);
    assign product_rnd = product + 47'sd32768;
    assign avg_new     = avg_base + product_rnd[43:16];
    assign smooth_sum  = avg_new + 28'sd128;

    always_comb
    begin
        in_valid_next        = in_valid_reg;
        in_word_next         = in_word_reg;
        out_valid_next       = out_valid_reg;
        out_word_next        = out_word_reg;
        ema_alpha_next       = ema_alpha_reg;
        jump_limit_next      = jump_limit_reg;
        stuck_limit_next     = stuck_limit_reg;
        last_good_next       = last_good_reg;
        last_good_valid_next = last_good_valid_reg;
        stuck_ref_next       = stuck_ref_reg;
        stuck_ref_valid_next = stuck_ref_valid_reg;
        same_count_next      = same_count_reg;
        average_next         = average_reg;
        average_valid_next   = average_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EMA_ALPHA:   ema_alpha_next   = cfg_data;
                CFG_JUMP_LIMIT:  jump_limit_next  = cfg_data[10:0];
                CFG_STUCK_LIMIT: stuck_limit_next = cfg_data[15:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (!in_stall)
        begin
            in_valid_next = in_valid;
            in_word_next  = in_word;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (sample_bad)
            begin
                out_word_next.status        = STATUS_INVALID;
                out_word_next.filtered_temp = '0;
                out_word_next.smoothed_temp = '0;
            end
            else
            begin
                last_good_next              = f;
                last_good_valid_next        = 1'b1;
                out_word_next.filtered_temp = f;
                if (!stuck_ref_valid_reg)
                begin
                    stuck_ref_next       = f;
                    stuck_ref_valid_next = 1'b1;
                    same_count_next      = '0;
                end
                else if (f != stuck_ref_reg)
                begin
                    stuck_ref_next  = f;
                    same_count_next = '0;
                end
                else
                begin
                    same_count_next = count_inc;
                end

                if (stuck)
                begin
                    same_count_next             = '0;
                    out_word_next.status        = STATUS_STUCK;
                    out_word_next.smoothed_temp = '0;
                end
                else
                begin
                    average_next                = avg_new;
                    average_valid_next          = 1'b1;
                    out_word_next.status        = STATUS_OK;
                    out_word_next.smoothed_temp = smooth_sum[27:8];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            in_word_reg         <= '0;
            out_valid_reg       <= 1'b0;
            out_word_reg        <= '0;
            ema_alpha_reg       <= EMA_ALPHA_RESET;
            jump_limit_reg      <= JUMP_LIMIT_RESET;
            stuck_limit_reg     <= STUCK_LIMIT_RESET;
            last_good_reg       <= '0;
            last_good_valid_reg <= 1'b0;
            stuck_ref_reg       <= '0;
            stuck_ref_valid_reg <= 1'b0;
            same_count_reg      <= '0;
            average_reg         <= '0;
            average_valid_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg        <= in_valid_next;
            in_word_reg         <= in_word_next;
            out_valid_reg       <= out_valid_next;
            out_word_reg        <= out_word_next;
            ema_alpha_reg       <= ema_alpha_next;
            jump_limit_reg      <= jump_limit_next;
            stuck_limit_reg     <= stuck_limit_next;
            last_good_reg       <= last_good_next;
            last_good_valid_reg <= last_good_valid_next;
            stuck_ref_reg       <= stuck_ref_next;
            stuck_ref_valid_reg <= stuck_ref_valid_next;
            same_count_reg      <= same_count_next;
            average_reg         <= average_next;
            average_valid_reg   <= average_valid_next;
        end
    end

    // first good sample sets both references together
    a_ref_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        last_good_valid_reg == stuck_ref_valid_reg)
        else $error("glitch and stuck references out of step");

    a_avg_needs_ref: assert property (@(posedge clk) disable iff (!rst_n)
        average_valid_reg |-> stuck_ref_valid_reg)
        else $error("average seeded without a reference");

    a_stuck_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !sample_bad && stuck |=> same_count_reg == 16'd0)
        else $error("repeat count not cleared after stuck");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled with room downstream");

    a_ok_has_average: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.status == STATUS_OK |-> average_valid_reg)
        else $error("ok word without a seeded average");

endmodule
